// ===== rtl/clx_pkg.sv =====
// clx_pkg: shared types, token kind codes and character class functions
// for the c subset lexer; no dependencies
package clx_pkg;

  localparam int CLX_MAX_WORD    = 64;
  localparam int CLX_QUEUE_DEPTH = 4;
  localparam int TOK_LEN_W       = 7;
  localparam int TOK_IDX_W       = 16;
  localparam int NUM_KW          = 11;
  localparam int NUM_SLOTS       = 3;

  // slot order inside one request: pending operator, word or string, punctuation
  localparam int SLOT_OP    = 0;
  localparam int SLOT_WORD  = 1;
  localparam int SLOT_PUNCT = 2;

  typedef enum logic [5:0] {
    KIND_HEADER    = 6'd0,
    KIND_TYPE      = 6'd1,
    KIND_VOID      = 6'd2,
    KIND_WHILE     = 6'd3,
    KIND_BREAK     = 6'd4,
    KIND_IF        = 6'd5,
    KIND_ELSE      = 6'd6,
    KIND_RETURN    = 6'd7,
    KIND_BOOL_LIT  = 6'd8,
    KIND_FLOAT_LIT = 6'd9,
    KIND_INT_LIT   = 6'd10,
    KIND_IDENT     = 6'd11,
    KIND_STRING    = 6'd12,
    KIND_SEMI      = 6'd13,
    KIND_COMMA     = 6'd14,
    KIND_LPAREN    = 6'd15,
    KIND_RPAREN    = 6'd16,
    KIND_LBRACE    = 6'd17,
    KIND_RBRACE    = 6'd18,
    KIND_LBRACK    = 6'd19,
    KIND_RBRACK    = 6'd20,
    KIND_PLUS      = 6'd21,
    KIND_MINUS     = 6'd22,
    KIND_STAR      = 6'd23,
    KIND_SLASH     = 6'd24,
    KIND_PERCENT   = 6'd25,
    KIND_LT        = 6'd26,
    KIND_GT        = 6'd27,
    KIND_NOT       = 6'd28,
    KIND_ASSIGN    = 6'd29,
    KIND_LE        = 6'd30,
    KIND_GE        = 6'd31,
    KIND_NE        = 6'd32,
    KIND_EQ        = 6'd33,
    KIND_UNKNOWN   = 6'd34
  } tok_kind_e;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LT     = 3'd1,
    OP_GT     = 3'd2,
    OP_NOT    = 3'd3,
    OP_ASSIGN = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    KW_VOID   = 4'd0,
    KW_BOOL   = 4'd1,
    KW_INT    = 4'd2,
    KW_FLOAT  = 4'd3,
    KW_WHILE  = 4'd4,
    KW_BREAK  = 4'd5,
    KW_IF     = 4'd6,
    KW_ELSE   = 4'd7,
    KW_RETURN = 4'd8,
    KW_TRUE   = 4'd9,
    KW_FALSE  = 4'd10
  } kw_e;

  typedef struct packed {
    tok_kind_e              kind;
    logic [TOK_LEN_W-1:0]   len;
    logic [TOK_IDX_W-1:0]   idx;
  } tok_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0]   valid;
    tok_t [NUM_SLOTS-1:0]   tok;
  } bundle_t;

  // keyword text, left aligned in six characters
  function automatic logic [47:0] kw_text(input kw_e k);
    logic [47:0] t;
    case (k)
      KW_VOID:   t = "void  ";
      KW_BOOL:   t = "bool  ";
      KW_INT:    t = "int   ";
      KW_FLOAT:  t = "float ";
      KW_WHILE:  t = "while ";
      KW_BREAK:  t = "break ";
      KW_IF:     t = "if    ";
      KW_ELSE:   t = "else  ";
      KW_RETURN: t = "return";
      KW_TRUE:   t = "true  ";
      KW_FALSE:  t = "false ";
      default:   t = "      ";
    endcase
    return t;
  endfunction

  function automatic logic [2:0] kw_len(input kw_e k);
    logic [2:0] n;
    case (k)
      KW_VOID, KW_BOOL, KW_ELSE, KW_TRUE:     n = 3'd4;
      KW_INT:                                 n = 3'd3;
      KW_FLOAT, KW_WHILE, KW_BREAK, KW_FALSE: n = 3'd5;
      KW_IF:                                  n = 3'd2;
      KW_RETURN:                              n = 3'd6;
      default:                                n = 3'd0;
    endcase
    return n;
  endfunction

  // one keyword character by position, space past the text, zero past the sixth
  function automatic logic [7:0] kw_char(input kw_e k, input logic [2:0] pos);
    logic [47:0] t;
    logic [7:0]  ch;
    t = kw_text(k);
    case (pos)
      3'd0:    ch = t[47:40];
      3'd1:    ch = t[39:32];
      3'd2:    ch = t[31:24];
      3'd3:    ch = t[23:16];
      3'd4:    ch = t[15:8];
      3'd5:    ch = t[7:0];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {" ", "\t", "\n"};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0" : "9"]};
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return c inside {["0" : "9"], ["A" : "Z"], ["a" : "z"], "_"};
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c inside {";", ",", "(", ")", "{", "}", "[", "]", "+", "-", "*", "/", "%"};
  endfunction

  function automatic tok_kind_e punct_kind(input logic [7:0] c);
    tok_kind_e k;
    case (c)
      ";":     k = KIND_SEMI;
      ",":     k = KIND_COMMA;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      "[":     k = KIND_LBRACK;
      "]":     k = KIND_RBRACK;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "%":     k = KIND_PERCENT;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic op_e op_code(input logic [7:0] c);
    op_e o;
    case (c)
      "<":     o = OP_LT;
      ">":     o = OP_GT;
      "!":     o = OP_NOT;
      "=":     o = OP_ASSIGN;
      default: o = OP_NONE;
    endcase
    return o;
  endfunction

  function automatic tok_kind_e op_single_kind(input op_e o);
    tok_kind_e k;
    case (o)
      OP_LT:     k = KIND_LT;
      OP_GT:     k = KIND_GT;
      OP_NOT:    k = KIND_NOT;
      OP_ASSIGN: k = KIND_ASSIGN;
      default:   k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic tok_kind_e op_pair_kind(input op_e o);
    tok_kind_e k;
    case (o)
      OP_LT:     k = KIND_LE;
      OP_GT:     k = KIND_GE;
      OP_NOT:    k = KIND_NE;
      OP_ASSIGN: k = KIND_EQ;
      default:   k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/clx_front.sv =====
// clx_front: per-byte lexer state and incremental word classification;
// turns each accepted byte into at most one request of up to three tokens. uses clx_pkg
module clx_front import clx_pkg::*; #(
  parameter int MaxWord = CLX_MAX_WORD
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] byte_i,
  input  logic       eoi_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output bundle_t    q_bundle_o
);

  localparam int WlW = $clog2(MaxWord + 2);
  localparam logic [WlW-1:0] MaxWl  = WlW'(MaxWord);
  localparam logic [WlW-1:0] OverWl = WlW'(MaxWord + 1);

  logic [WlW-1:0]    wl_q, wl_d;
  logic [NUM_KW-1:0] km_q, km_d;
  logic              ad_q, ad_d;
  logic [1:0]        dc_q, dc_d;
  logic              io_q, io_d;
  logic [1:0]        hm_q, hm_d;
  logic              prol_q, prol_d;
  logic              str_q, str_d;
  op_e               pend_q, pend_d;
  logic [TOK_IDX_W-1:0] cnt_q, cnt_d;

  logic              acc;
  logic [NUM_KW-1:0] kw_hit;
  tok_kind_e         main_kind;
  logic              pro_emit;
  tok_kind_e         pro_kind;
  logic              pro_type;

  logic [WlW-1:0]    app_wl;
  logic [NUM_KW-1:0] app_km;
  logic              app_ad;
  logic [1:0]        app_dc;
  logic              app_io;
  logic [1:0]        app_hm;

  logic [WlW-1:0]    str_wl;
  logic [NUM_SLOTS-1:0] s_valid;
  tok_kind_e         s_kind [NUM_SLOTS];
  logic [TOK_LEN_W-1:0] s_len [NUM_SLOTS];

  function automatic logic [TOK_LEN_W-1:0] sat_len(input logic [WlW-1:0] l);
    return TOK_LEN_W'((l > MaxWl) ? MaxWl : l);
  endfunction

  assign acc = push_i && !q_full_i;

  // keyword hits on the word so far
  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      kw_hit[k] = km_q[k] && (wl_q == WlW'(kw_len(kw_e'(4'(k)))));
    end
  end

  always_comb begin
    if (wl_q > MaxWl) begin
      main_kind = KIND_UNKNOWN;
    end else if (kw_hit[KW_WHILE]) begin
      main_kind = KIND_WHILE;
    end else if (kw_hit[KW_VOID]) begin
      main_kind = KIND_VOID;
    end else if (kw_hit[KW_BOOL] || kw_hit[KW_INT] || kw_hit[KW_FLOAT]) begin
      main_kind = KIND_TYPE;
    end else if (kw_hit[KW_BREAK]) begin
      main_kind = KIND_BREAK;
    end else if (kw_hit[KW_IF]) begin
      main_kind = KIND_IF;
    end else if (kw_hit[KW_ELSE]) begin
      main_kind = KIND_ELSE;
    end else if (kw_hit[KW_TRUE] || kw_hit[KW_FALSE]) begin
      main_kind = KIND_BOOL_LIT;
    end else if (ad_q && dc_q == 2'd1) begin
      main_kind = KIND_FLOAT_LIT;
    end else if (ad_q && dc_q == 2'd0) begin
      main_kind = KIND_INT_LIT;
    end else if (kw_hit[KW_RETURN]) begin
      main_kind = KIND_RETURN;
    end else if (io_q) begin
      main_kind = KIND_IDENT;
    end else begin
      main_kind = KIND_UNKNOWN;
    end
  end

  // prologue word end: header, type or discard
  always_comb begin
    pro_emit = 1'b0;
    pro_kind = KIND_HEADER;
    pro_type = 1'b0;
    if (wl_q == '0) begin
      pro_emit = 1'b0;
    end else if (wl_q > MaxWl) begin
      pro_emit = (hm_q == 2'b11);
      pro_kind = KIND_UNKNOWN;
    end else if (kw_hit[KW_VOID] || kw_hit[KW_BOOL] || kw_hit[KW_INT] || kw_hit[KW_FLOAT]) begin
      pro_emit = 1'b1;
      pro_kind = KIND_TYPE;
      pro_type = 1'b1;
    end else if (hm_q == 2'b11) begin
      pro_emit = 1'b1;
      pro_kind = KIND_HEADER;
    end
  end

  // append one character to the word
  always_comb begin
    app_wl = wl_q;
    app_km = km_q;
    app_ad = ad_q;
    app_dc = dc_q;
    app_io = io_q;
    app_hm = hm_q;
    if (wl_q >= MaxWl) begin
      app_wl = OverWl;
    end else begin
      for (int k = 0; k < NUM_KW; k++) begin
        if (wl_q >= WlW'(kw_len(kw_e'(4'(k)))) ||
            kw_char(kw_e'(4'(k)), wl_q[2:0]) != byte_i) begin
          app_km[k] = 1'b0;
        end
      end
      if (byte_i == ".") begin
        if (dc_q != 2'd2) app_dc = dc_q + 2'd1;
      end else if (!is_digit(byte_i)) begin
        app_ad = 1'b0;
      end
      if ((wl_q == '0 && is_digit(byte_i)) || !is_ident_char(byte_i)) app_io = 1'b0;
      app_hm[0] = hm_q[0] | (wl_q == '0 && byte_i == "#");
      app_hm[1] = (byte_i == ">");
      app_wl = wl_q + WlW'(1);
    end
  end

  assign str_wl = (wl_q <= MaxWl) ? wl_q + WlW'(1) : wl_q;

  always_comb begin
    wl_d   = wl_q;
    km_d   = km_q;
    ad_d   = ad_q;
    dc_d   = dc_q;
    io_d   = io_q;
    hm_d   = hm_q;
    prol_d = prol_q;
    str_d  = str_q;
    pend_d = pend_q;
    s_valid = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      s_kind[s] = KIND_UNKNOWN;
      s_len[s]  = '0;
    end
    if (acc) begin
      if (eoi_i) begin
        if (str_q) begin
          s_valid[SLOT_WORD] = 1'b1;
          s_kind[SLOT_WORD]  = KIND_UNKNOWN;
          s_len[SLOT_WORD]   = sat_len(wl_q);
          str_d = 1'b0;
        end else begin
          if (pend_q != OP_NONE) begin
            s_valid[SLOT_OP] = 1'b1;
            s_kind[SLOT_OP]  = op_single_kind(pend_q);
            s_len[SLOT_OP]   = TOK_LEN_W'(1);
          end
          pend_d = OP_NONE;
          if (prol_q) begin
            s_valid[SLOT_WORD] = pro_emit;
            s_kind[SLOT_WORD]  = pro_kind;
            if (pro_type) prol_d = 1'b0;
          end else begin
            s_valid[SLOT_WORD] = (wl_q != '0);
            s_kind[SLOT_WORD]  = main_kind;
          end
          s_len[SLOT_WORD] = sat_len(wl_q);
        end
        wl_d = '0; km_d = '1; ad_d = 1'b1; dc_d = '0; io_d = 1'b1; hm_d = '0;
      end else if (str_q) begin
        if (byte_i == "\"") begin
          s_valid[SLOT_WORD] = 1'b1;
          s_kind[SLOT_WORD]  = (str_wl > MaxWl) ? KIND_UNKNOWN : KIND_STRING;
          s_len[SLOT_WORD]   = sat_len(str_wl);
          str_d = 1'b0;
          wl_d = '0; km_d = '1; ad_d = 1'b1; dc_d = '0; io_d = 1'b1; hm_d = '0;
        end else begin
          wl_d = str_wl;
        end
      end else begin
        if (pend_q != OP_NONE) begin
          s_valid[SLOT_OP] = 1'b1;
          pend_d = OP_NONE;
          if (byte_i == "=") begin
            s_kind[SLOT_OP] = op_pair_kind(pend_q);
            s_len[SLOT_OP]  = TOK_LEN_W'(2);
          end else begin
            s_kind[SLOT_OP] = op_single_kind(pend_q);
            s_len[SLOT_OP]  = TOK_LEN_W'(1);
          end
        end
        if (pend_q != OP_NONE && byte_i == "=") begin
          wl_d = wl_q;
        end else if (prol_q) begin
          if (is_space(byte_i)) begin
            s_valid[SLOT_WORD] = pro_emit;
            s_kind[SLOT_WORD]  = pro_kind;
            s_len[SLOT_WORD]   = sat_len(wl_q);
            if (pro_type) prol_d = 1'b0;
            wl_d = '0; km_d = '1; ad_d = 1'b1; dc_d = '0; io_d = 1'b1; hm_d = '0;
          end else begin
            wl_d = app_wl; km_d = app_km; ad_d = app_ad;
            dc_d = app_dc; io_d = app_io; hm_d = app_hm;
          end
        end else if (is_space(byte_i) || byte_i == "\"" || is_punct(byte_i) ||
                     op_code(byte_i) != OP_NONE) begin
          s_valid[SLOT_WORD] = (wl_q != '0);
          s_kind[SLOT_WORD]  = main_kind;
          s_len[SLOT_WORD]   = sat_len(wl_q);
          wl_d = '0; km_d = '1; ad_d = 1'b1; dc_d = '0; io_d = 1'b1; hm_d = '0;
          if (byte_i == "\"") begin
            str_d = 1'b1;
            wl_d  = WlW'(1);
          end else if (op_code(byte_i) != OP_NONE) begin
            pend_d = op_code(byte_i);
          end else if (is_punct(byte_i)) begin
            s_valid[SLOT_PUNCT] = 1'b1;
            s_kind[SLOT_PUNCT]  = punct_kind(byte_i);
            s_len[SLOT_PUNCT]   = TOK_LEN_W'(1);
          end
        end else begin
          wl_d = app_wl; km_d = app_km; ad_d = app_ad;
          dc_d = app_dc; io_d = app_io; hm_d = app_hm;
        end
      end
    end
  end

  // running index per slot
  always_comb begin
    cnt_d = cnt_q;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      q_bundle_o.tok[s].kind = s_kind[s];
      q_bundle_o.tok[s].len  = s_len[s];
      q_bundle_o.tok[s].idx  = cnt_d;
      if (s_valid[s]) cnt_d = cnt_d + TOK_IDX_W'(1);
    end
    q_bundle_o.valid = s_valid;
  end

  assign q_push_o = |s_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q   <= '0;
      km_q   <= '1;
      ad_q   <= 1'b1;
      dc_q   <= '0;
      io_q   <= 1'b1;
      hm_q   <= '0;
      prol_q <= 1'b1;
      str_q  <= 1'b0;
      pend_q <= OP_NONE;
      cnt_q  <= '0;
    end else begin
      wl_q   <= wl_d;
      km_q   <= km_d;
      ad_q   <= ad_d;
      dc_q   <= dc_d;
      io_q   <= io_d;
      hm_q   <= hm_d;
      prol_q <= prol_d;
      str_q  <= str_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== rtl/clx_queue.sv =====
// clx_queue: short request queue between the lexer front and the token back;
// uses clx_pkg
module clx_queue import clx_pkg::*; #(
  parameter int Depth = CLX_QUEUE_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t bundle_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    empty_o,
  output bundle_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  bundle_t         mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    if (do_pop)  rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/clx_back.sv =====
// clx_back: delivers the tokens of the oldest request one at a time,
// marks the last one of each request; uses clx_pkg
module clx_back import clx_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bundle_t              head_i,
  input  logic                 empty_i,
  input  logic                 pop_i,
  output logic                 q_pop_o,
  output logic [5:0]           token_kind_o,
  output logic [TOK_LEN_W-1:0] token_length_o,
  output logic [TOK_IDX_W-1:0] token_index_o,
  output logic                 last_o
);

  logic [NUM_SLOTS-1:0] done_q, done_d;
  logic [NUM_SLOTS-1:0] remain, sel;
  tok_t                 cur;

  assign remain = head_i.valid & ~done_q;

  // lowest remaining slot
  always_comb begin
    sel = '0;
    cur = head_i.tok[NUM_SLOTS-1];
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (remain[s]) begin
        sel = '0;
        sel[s] = 1'b1;
        cur = head_i.tok[s];
      end
    end
  end

  assign last_o         = ((remain & ~sel) == '0);
  assign token_kind_o   = cur.kind;
  assign token_length_o = cur.len;
  assign token_index_o  = cur.idx;
  assign q_pop_o        = pop_i && !empty_i && last_o;

  always_comb begin
    done_d = done_q;
    if (pop_i && !empty_i) begin
      done_d = last_o ? '0 : (done_q | sel);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
    end else begin
      done_q <= done_d;
    end
  end

endmodule

// ===== rtl/c_subset_lexer_core.sv =====
// c_subset_lexer_core: byte-serial lexer for a small c subset, top level
// a token can be popped once its request is registered in the queue
// throughput: one byte per cycle in while the queue is not full; one token per
// cycle out, a byte's tokens being popped one by one; the request queue absorbs
// the difference. reset clears all lexer state and empties the queue
module c_subset_lexer_core import clx_pkg::*; #(
  parameter int MaxWord    = CLX_MAX_WORD,
  parameter int QueueDepth = CLX_QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           byte_in_i,
  input  logic                 end_of_input_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [5:0]           token_kind_o,
  output logic [TOK_LEN_W-1:0] token_length_o,
  output logic [TOK_IDX_W-1:0] token_index_o,
  output logic                 last_o
);

  logic    q_push, q_full, q_pop, q_empty;
  bundle_t q_in, q_head;

  clx_front #(
    .MaxWord (MaxWord)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .byte_i     (byte_in_i),
    .eoi_i      (end_of_input_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_bundle_o (q_in)
  );

  clx_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .bundle_i (q_in),
    .full_o   (q_full),
    .pop_i    (q_pop),
    .empty_o  (q_empty),
    .head_o   (q_head)
  );

  clx_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (q_head),
    .empty_i        (q_empty),
    .pop_i          (pop),
    .q_pop_o        (q_pop),
    .token_kind_o   (token_kind_o),
    .token_length_o (token_length_o),
    .token_index_o  (token_index_o),
    .last_o         (last_o)
  );

  assign full  = q_full;
  assign empty = q_empty;

endmodule
